### hw/rtl/wgc_pkg.sv
`default_nettype none
package wgc_pkg;

   localparam int COORD_BITS     = 20;
   localparam int WAYPOINTS      = 32;
   localparam int SLOT_BITS      = 5;
   localparam int DIFF_BITS      = COORD_BITS + 1;
   localparam int HEAD_BITS      = 15;
   localparam int CORDIC_ITERS   = 20;
   localparam int CORDIC_SHIFT   = 40 - COORD_BITS;
   localparam int CORDIC_BITS    = 44;
   localparam int ANGLE_BITS     = 26;
   localparam int ITER_BITS      = 5;
   localparam int REQ_DATA_BITS  = 144;
   localparam int RSP_DATA_BITS  = 24;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [0:0] MODE_LOAD = 1'b0;

   localparam logic [2:0] CSR_CAPTURE_RADIUS = 3'd0;
   localparam logic [2:0] CSR_ROLL_P_GAIN    = 3'd1;
   localparam logic [2:0] CSR_ROLL_I_GAIN    = 3'd2;
   localparam logic [2:0] CSR_PITCH_P_GAIN   = 3'd3;
   localparam logic [2:0] CSR_PITCH_I_GAIN   = 3'd4;
   localparam logic [2:0] CSR_ROLL_LIMIT     = 3'd5;
   localparam logic [2:0] CSR_PITCH_LIMIT    = 3'd6;
   localparam logic [2:0] CSR_WAYPOINT_COUNT = 3'd7;

   localparam logic [2:0] MUL_DN_DN  = 3'd0;
   localparam logic [2:0] MUL_DE_DE  = 3'd1;
   localparam logic [2:0] MUL_DH_DH  = 3'd2;
   localparam logic [2:0] MUL_R_R    = 3'd3;
   localparam logic [2:0] MUL_ERR_RI = 3'd4;
   localparam logic [2:0] MUL_ERR_RP = 3'd5;
   localparam logic [2:0] MUL_DH_PI  = 3'd6;
   localparam logic [2:0] MUL_DH_PP  = 3'd7;

   typedef struct packed {
      logic                 accept;
      logic                 diff_ld;
      logic [2:0]           mul_sel;
      logic                 sq_clr;
      logic                 sq_add;
      logic                 cap_chk;
      logic                 cordic_init;
      logic                 cordic_step;
      logic [ITER_BITS-1:0] iter;
      logic                 err_ld;
      logic                 racc_ld;
      logic                 rsum_ld;
      logic                 pacc_ld;
      logic                 psum_ld;
      logic                 out_ld;
   } wgc_cmd_type;

   typedef struct packed {
      logic out_free;
   } wgc_status_type;

   function automatic logic signed [ANGLE_BITS-1:0] atan_q16(input logic [ITER_BITS-1:0] i);
      logic signed [ANGLE_BITS-1:0] r;
      case (i)
         5'd0:    r = 26'sd2949120;
         5'd1:    r = 26'sd1740967;
         5'd2:    r = 26'sd919879;
         5'd3:    r = 26'sd466945;
         5'd4:    r = 26'sd234379;
         5'd5:    r = 26'sd117304;
         5'd6:    r = 26'sd58666;
         5'd7:    r = 26'sd29335;
         5'd8:    r = 26'sd14668;
         5'd9:    r = 26'sd7334;
         5'd10:   r = 26'sd3667;
         5'd11:   r = 26'sd1833;
         5'd12:   r = 26'sd917;
         5'd13:   r = 26'sd458;
         5'd14:   r = 26'sd229;
         5'd15:   r = 26'sd115;
         5'd16:   r = 26'sd57;
         5'd17:   r = 26'sd29;
         5'd18:   r = 26'sd14;
         5'd19:   r = 26'sd7;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/waypoint_guidance_controller_core.sv
// Waypoint guidance controller.
// req channel: req_tuser selects the word kind (0 load, 1 telemetry);
// req_tdata carries slot, waypoint north/east/height, vehicle north/east/
// altitude and heading. A load writes one route table slot and gives no
// result. A telemetry word runs a capture test, a 20-step CORDIC bearing
// and two PI laws through one shared multiplier, and its result goes to
// the result register. One telemetry word is in work at a time; the next
// word is accepted once the last one is loaded into the result register.
// rsp channel: one word per telemetry word with roll and pitch commands,
// the target index and the route finished flag. The result register holds
// a word while the receiver stalls; the next word may already be accepted
// and worked on, but waits at its end until the register frees.
// csr channel: always ready, one register write per handshake; write only
// while the block is idle.
// Reset (synchronous) clears the index, the accumulators, the finished
// flag and loads the register defaults; the route table must be loaded
// before use.
`default_nettype none
module waypoint_guidance_controller_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // mode
   input  wire logic                                 req_tuser,
   // load_slot, load_north, load_east, load_height, pos_north, pos_east,
   // altitude, heading
   input  wire logic [wgc_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // roll_cmd, pitch_cmd, target_index, final_reached
   output logic [wgc_pkg::RSP_DATA_BITS-1:0]         rsp_tdata,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [wgc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [wgc_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   wgc_pkg::wgc_cmd_type    cmd;
   wgc_pkg::wgc_status_type status;

   assign csr_ready = 1'b1;

   wgc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .status     (status),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   wgc_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

endmodule
`default_nettype wire

### hw/rtl/wgc_ctrl.sv
`default_nettype none
module wgc_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic                   req_tuser,
   input  wire wgc_pkg::wgc_status_type status,
   output logic                        req_tready,
   output wgc_pkg::wgc_cmd_type        cmd
);

   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_RD    = 5'd1;
   localparam logic [4:0] ST_DIFF  = 5'd2;
   localparam logic [4:0] ST_SQ0   = 5'd3;
   localparam logic [4:0] ST_SQ1   = 5'd4;
   localparam logic [4:0] ST_SQ2   = 5'd5;
   localparam logic [4:0] ST_SQ3   = 5'd6;
   localparam logic [4:0] ST_CAP   = 5'd7;
   localparam logic [4:0] ST_RD2   = 5'd8;
   localparam logic [4:0] ST_DIFF2 = 5'd9;
   localparam logic [4:0] ST_CINIT = 5'd10;
   localparam logic [4:0] ST_CITER = 5'd11;
   localparam logic [4:0] ST_ERR   = 5'd12;
   localparam logic [4:0] ST_MRI   = 5'd13;
   localparam logic [4:0] ST_MRP   = 5'd14;
   localparam logic [4:0] ST_MPI   = 5'd15;
   localparam logic [4:0] ST_MPP   = 5'd16;
   localparam logic [4:0] ST_PSUM  = 5'd17;
   localparam logic [4:0] ST_OUT   = 5'd18;

   localparam logic [wgc_pkg::ITER_BITS-1:0] LAST_ITER =
      wgc_pkg::ITER_BITS'(wgc_pkg::CORDIC_ITERS - 1);

   logic [4:0]                      state_ff, state_in;
   logic [wgc_pkg::ITER_BITS-1:0]   iter_ff, iter_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
      end
   end

   always_comb begin
      cmd        = '0;
      cmd.iter   = iter_ff;
      state_in   = state_ff;
      iter_in    = iter_ff;
      req_tready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (req_tuser != wgc_pkg::MODE_LOAD[0]) state_in = ST_RD;
            end
         end
         ST_RD:    state_in = ST_DIFF;
         ST_DIFF: begin
            cmd.diff_ld = 1'b1;
            state_in    = ST_SQ0;
         end
         ST_SQ0: begin
            cmd.mul_sel = wgc_pkg::MUL_DN_DN;
            state_in    = ST_SQ1;
         end
         ST_SQ1: begin
            cmd.mul_sel = wgc_pkg::MUL_DE_DE;
            cmd.sq_clr  = 1'b1;
            state_in    = ST_SQ2;
         end
         ST_SQ2: begin
            cmd.mul_sel = wgc_pkg::MUL_DH_DH;
            cmd.sq_add  = 1'b1;
            state_in    = ST_SQ3;
         end
         ST_SQ3: begin
            cmd.mul_sel = wgc_pkg::MUL_R_R;
            cmd.sq_add  = 1'b1;
            state_in    = ST_CAP;
         end
         ST_CAP: begin
            cmd.cap_chk = 1'b1;
            state_in    = ST_RD2;
         end
         ST_RD2:   state_in = ST_DIFF2;
         ST_DIFF2: begin
            cmd.diff_ld = 1'b1;
            state_in    = ST_CINIT;
         end
         ST_CINIT: begin
            cmd.cordic_init = 1'b1;
            iter_in         = '0;
            state_in        = ST_CITER;
         end
         ST_CITER: begin
            cmd.cordic_step = 1'b1;
            if (iter_ff == LAST_ITER) begin
               state_in = ST_ERR;
            end else begin
               iter_in = iter_ff + 1'b1;
            end
         end
         ST_ERR: begin
            cmd.err_ld = 1'b1;
            state_in   = ST_MRI;
         end
         ST_MRI: begin
            cmd.mul_sel = wgc_pkg::MUL_ERR_RI;
            state_in    = ST_MRP;
         end
         ST_MRP: begin
            cmd.mul_sel = wgc_pkg::MUL_ERR_RP;
            cmd.racc_ld = 1'b1;
            state_in    = ST_MPI;
         end
         ST_MPI: begin
            cmd.mul_sel = wgc_pkg::MUL_DH_PI;
            cmd.rsum_ld = 1'b1;
            state_in    = ST_MPP;
         end
         ST_MPP: begin
            cmd.mul_sel = wgc_pkg::MUL_DH_PP;
            cmd.pacc_ld = 1'b1;
            state_in    = ST_PSUM;
         end
         ST_PSUM: begin
            cmd.psum_ld = 1'b1;
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_ld = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

### hw/rtl/wgc_dp.sv
`default_nettype none
module wgc_dp (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire wgc_pkg::wgc_cmd_type                  cmd,
   output wgc_pkg::wgc_status_type                    status,
   input  wire logic                                  req_tuser,
   input  wire logic [wgc_pkg::REQ_DATA_BITS-1:0]     req_tdata,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic [wgc_pkg::RSP_DATA_BITS-1:0]          rsp_tdata,
   input  wire logic                                  csr_valid,
   input  wire logic [wgc_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [wgc_pkg::CSR_DATA_BITS-1:0]     csr_data
);

   localparam int CB = wgc_pkg::COORD_BITS;
   localparam int DB = wgc_pkg::DIFF_BITS;
   localparam int XB = wgc_pkg::CORDIC_BITS;
   localparam int AB = wgc_pkg::ANGLE_BITS;

   // configuration
   logic [15:0] radius_ff, rp_ff, ri_ff, pp_ff, pi_ff;
   logic [6:0]  rlim_ff, plim_ff;
   logic [5:0]  count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 16'd120;
         rp_ff     <= 16'd282;
         ri_ff     <= 16'd0;
         pp_ff     <= 16'd1250;
         pi_ff     <= 16'd0;
         rlim_ff   <= 7'd30;
         plim_ff   <= 7'd20;
         count_ff  <= 6'd20;
      end else if (csr_valid) begin
         case (csr_index)
            wgc_pkg::CSR_CAPTURE_RADIUS: radius_ff <= csr_data;
            wgc_pkg::CSR_ROLL_P_GAIN:    rp_ff     <= csr_data;
            wgc_pkg::CSR_ROLL_I_GAIN:    ri_ff     <= csr_data;
            wgc_pkg::CSR_PITCH_P_GAIN:   pp_ff     <= csr_data;
            wgc_pkg::CSR_PITCH_I_GAIN:   pi_ff     <= csr_data;
            wgc_pkg::CSR_ROLL_LIMIT:     rlim_ff   <= csr_data[6:0];
            wgc_pkg::CSR_PITCH_LIMIT:    plim_ff   <= csr_data[6:0];
            wgc_pkg::CSR_WAYPOINT_COUNT: count_ff  <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   // input word fields
   logic [wgc_pkg::SLOT_BITS-1:0] slot;
   logic [3*CB-1:0]               load_word;
   assign slot      = req_tdata[4:0];
   assign load_word = req_tdata[64:5];

   logic signed [CB-1:0] pn_ff, pe_ff, alt_ff;
   logic signed [wgc_pkg::HEAD_BITS-1:0] hd_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pn_ff  <= req_tdata[84:65];
         pe_ff  <= req_tdata[104:85];
         alt_ff <= req_tdata[124:105];
         hd_ff  <= req_tdata[139:125];
      end
   end

   // route table
   logic [wgc_pkg::SLOT_BITS-1:0] cur_ff, cur_in;
   logic                          fin_ff, fin_in;
   logic [3*CB-1:0] route_mem [wgc_pkg::WAYPOINTS];
   logic [3*CB-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept && (req_tuser == wgc_pkg::MODE_LOAD[0])) route_mem[slot] <= load_word;
      rd_ff <= route_mem[cur_ff];
   end

   // differences
   logic signed [DB-1:0] dn_in, de_in, dh_in, dn_ff, de_ff, dh_ff;
   logic                 near_in, near_ff, zero_ff;

   assign dn_in = DB'($signed(rd_ff[CB-1:0]))      - DB'(pn_ff);
   assign de_in = DB'($signed(rd_ff[2*CB-1:CB]))   - DB'(pe_ff);
   assign dh_in = DB'($signed(rd_ff[3*CB-1:2*CB])) - DB'(alt_ff);

   function automatic logic in_near(input logic signed [DB-1:0] v);
      return (v <= DB'(65535)) && (v >= -DB'(65535));
   endfunction

   assign near_in = in_near(dn_in) && in_near(de_in) && in_near(dh_in);

   always_ff @(posedge clock) begin
      if (cmd.diff_ld) begin
         dn_ff   <= dn_in;
         de_ff   <= de_in;
         dh_ff   <= dh_in;
         near_ff <= near_in;
         zero_ff <= (dn_in == '0) && (de_in == '0);
      end
   end

   // shared multiplier
   logic signed [15:0] err_ff;
   logic signed [DB-1:0] mul_a;
   logic signed [17:0]   mul_b;
   logic signed [38:0]   prod_ff;

   always_comb begin
      case (cmd.mul_sel)
         wgc_pkg::MUL_DN_DN: begin mul_a = dn_ff; mul_b = dn_ff[17:0]; end
         wgc_pkg::MUL_DE_DE: begin mul_a = de_ff; mul_b = de_ff[17:0]; end
         wgc_pkg::MUL_DH_DH: begin mul_a = dh_ff; mul_b = dh_ff[17:0]; end
         wgc_pkg::MUL_R_R: begin
            mul_a = $signed({5'b0, radius_ff});
            mul_b = $signed({2'b0, radius_ff});
         end
         wgc_pkg::MUL_ERR_RI: begin mul_a = DB'(err_ff); mul_b = $signed({2'b0, ri_ff}); end
         wgc_pkg::MUL_ERR_RP: begin mul_a = DB'(err_ff); mul_b = $signed({2'b0, rp_ff}); end
         wgc_pkg::MUL_DH_PI:  begin mul_a = dh_ff; mul_b = $signed({2'b0, pi_ff}); end
         wgc_pkg::MUL_DH_PP:  begin mul_a = dh_ff; mul_b = $signed({2'b0, pp_ff}); end
         default:             begin mul_a = dh_ff; mul_b = $signed({2'b0, pp_ff}); end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= 39'(mul_a) * 39'(mul_b);
   end

   // capture test
   logic [34:0] sum_ff;
   logic [5:0]  count_sat;
   logic        captured;

   always_ff @(posedge clock) begin
      if (cmd.sq_clr) sum_ff <= prod_ff[34:0];
      else if (cmd.sq_add) sum_ff <= sum_ff + prod_ff[34:0];
   end

   assign count_sat = (count_ff == 6'd0) ? 6'd1 :
                      (count_ff > 6'(wgc_pkg::WAYPOINTS)) ? 6'(wgc_pkg::WAYPOINTS) : count_ff;
   assign captured  = near_ff && (sum_ff <= prod_ff[34:0]);

   always_comb begin
      cur_in = cur_ff;
      fin_in = fin_ff;
      if (cmd.cap_chk && captured) begin
         if (({1'b0, cur_ff} + 6'd1) < count_sat) cur_in = cur_ff + 1'b1;
         else fin_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= '0;
         fin_ff <= 1'b0;
      end else begin
         cur_ff <= cur_in;
         fin_ff <= fin_in;
      end
   end

   // bearing, one rotation a cycle
   logic signed [XB-1:0] x_ff, y_ff, xs, ys, xsh, ysh;
   logic signed [AB-1:0] z_ff;

   assign xs  = {{(XB-DB-wgc_pkg::CORDIC_SHIFT){dn_ff[DB-1]}}, dn_ff,
                 {wgc_pkg::CORDIC_SHIFT{1'b0}}};
   assign ys  = {{(XB-DB-wgc_pkg::CORDIC_SHIFT){de_ff[DB-1]}}, de_ff,
                 {wgc_pkg::CORDIC_SHIFT{1'b0}}};
   assign xsh = x_ff >>> cmd.iter;
   assign ysh = y_ff >>> cmd.iter;

   always_ff @(posedge clock) begin
      if (cmd.cordic_init) begin
         if (xs < 0) begin
            if (ys >= 0) begin
               x_ff <= ys;
               y_ff <= -xs;
               z_ff <= AB'(5898240);
            end else begin
               x_ff <= -ys;
               y_ff <= xs;
               z_ff <= -AB'(5898240);
            end
         end else begin
            x_ff <= xs;
            y_ff <= ys;
            z_ff <= '0;
         end
      end else if (cmd.cordic_step) begin
         if (y_ff >= 0) begin
            x_ff <= x_ff + ysh;
            y_ff <= y_ff - xsh;
            z_ff <= z_ff + wgc_pkg::atan_q16(cmd.iter);
         end else begin
            x_ff <= x_ff - ysh;
            y_ff <= y_ff + xsh;
            z_ff <= z_ff - wgc_pkg::atan_q16(cmd.iter);
         end
      end
   end

   // heading error, wrapped
   logic signed [AB-1:0] z_rnd;
   logic signed [16:0]   ang, err_raw, err_wrap;

   assign z_rnd = (z_ff + AB'(512)) >>> 10;
   assign ang   = zero_ff ? '0 : z_rnd[16:0];
   assign err_raw = 17'(hd_ff) + ang;

   always_comb begin
      if (err_raw > 17'sd11520) err_wrap = err_raw - 17'sd23040;
      else if (err_raw <= -17'sd11520) err_wrap = err_raw + 17'sd23040;
      else err_wrap = err_raw;
   end

   always_ff @(posedge clock) begin
      if (cmd.err_ld) err_ff <= err_wrap[15:0];
   end

   // PI laws
   logic signed [31:0] racc_ff, pacc_ff;
   logic signed [32:0] racc_s;
   logic signed [39:0] pacc_s;
   logic signed [33:0] rsum_ff;
   logic signed [39:0] psum_ff;

   assign racc_s = 33'(racc_ff) + prod_ff[32:0];
   assign pacc_s = 40'(pacc_ff) + 40'(prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         racc_ff <= '0;
         pacc_ff <= '0;
      end else begin
         if (cmd.racc_ld) begin
            if (racc_s > 33'sh0_7FFF_FFFF) racc_ff <= 32'sh7FFF_FFFF;
            else if (racc_s < -33'sh0_8000_0000) racc_ff <= 32'sh8000_0000;
            else racc_ff <= racc_s[31:0];
         end
         if (cmd.pacc_ld) begin
            if (pacc_s > 40'sh7F_FFFF_FFFF >>> 8) pacc_ff <= 32'sh7FFF_FFFF;
            else if (pacc_s < -40'sh00_8000_0000) pacc_ff <= 32'sh8000_0000;
            else pacc_ff <= pacc_s[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsum_ld) rsum_ff <= prod_ff[33:0] + 34'(racc_ff);
      if (cmd.psum_ld) psum_ff <= 40'(prod_ff) + 40'(pacc_ff);
   end

   function automatic logic signed [7:0] clamp_cmd(input logic signed [39:0] v,
                                                    input logic [6:0] lim);
      logic [6:0]          l;
      logic signed [39:0]  lw;
      l  = (lim > 7'd90) ? 7'd90 : lim;
      lw = 40'($signed({1'b0, l}));
      if (v > lw) return 8'($signed({1'b0, l}));
      if (v < -lw) return -8'($signed({1'b0, l}));
      return v[7:0];
   endfunction

   logic signed [39:0] rq, pq;
   logic signed [7:0]  roll_cmd, pitch_cmd;

   assign rq = (40'(rsum_ff) + (rsum_ff[33] ? 40'sd16383 : 40'sd0)) >>> 14;
   assign pq = (psum_ff + (psum_ff[39] ? 40'sd4095 : 40'sd0)) >>> 12;
   assign roll_cmd  = clamp_cmd(rq, rlim_ff);
   assign pitch_cmd = clamp_cmd(pq, plim_ff);

   // result register
   logic                             rsp_valid_ff;
   logic [wgc_pkg::RSP_DATA_BITS-1:0] rsp_data_ff;

   assign status.out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_ld) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_ld) rsp_data_ff <= {2'b0, fin_ff, cur_ff, pitch_cmd, roll_cmd};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_ld |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten while pending");
   a_fin_sticky: assert property (@(posedge clock) disable iff (reset)
      fin_ff |=> fin_ff)
      else $error("route finished flag dropped");
   a_cur_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.cap_chk |=> $stable(cur_ff))
      else $error("waypoint index moved outside capture check");

endmodule
`default_nettype wire

### tb/waypoint_guidance_checker.sv
`default_nettype none
module waypoint_guidance_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   input  wire logic                               req_tready,
   input  wire logic                               req_tuser,
   input  wire logic [wgc_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  wire logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic [wgc_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input  wire logic                               csr_valid,
   input  wire logic                               csr_ready,
   input  wire logic [wgc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [wgc_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output int                                      fail_count,
   output int                                      pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic       final_reached;
      logic [4:0] target_index;
      logic [7:0] pitch_cmd;
      logic [7:0] roll_cmd;
   } guidance_word_type;

   localparam longint ATAN_STEP [wgc_pkg::CORDIC_ITERS] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};
   localparam longint HALF_TURN = 11520;
   localparam longint FULL_TURN = 23040;
   localparam longint QUARTER   = 5898240;
   localparam longint NEAR_MAX  = 65535;
   localparam longint CMD_MAX   = 90;
   localparam longint ACC_MAX   = 64'sd2147483647;
   localparam longint ACC_MIN   = -64'sd2147483648;

   longint route_north [wgc_pkg::WAYPOINTS];
   longint route_east [wgc_pkg::WAYPOINTS];
   longint route_height [wgc_pkg::WAYPOINTS];
   int unsigned target;
   longint roll_acc, pitch_acc;
   logic finished;
   longint radius, roll_p, roll_i, pitch_p, pitch_i, roll_lim, pitch_lim, route_len;
   guidance_word_type command_queue [$];

   function automatic longint magnitude(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint bearing_atan2(longint y, longint x);
      longint z, t, xs, ys;
      z = 0;
      if (x == 0 && y == 0) return 0;
      x = x * (64'sd1 << wgc_pkg::CORDIC_SHIFT);
      y = y * (64'sd1 << wgc_pkg::CORDIC_SHIFT);
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = QUARTER;
         end else begin
            t = x; x = -y; y = t; z = -QUARTER;
         end
      end
      for (int i = 0; i < wgc_pkg::CORDIC_ITERS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys; y = y - xs; z += ATAN_STEP[i];
         end else begin
            x = x - ys; y = y + xs; z -= ATAN_STEP[i];
         end
      end
      return (z + 512) >>> 10;
   endfunction

   function automatic longint saturate_acc(longint s);
      return s > ACC_MAX ? ACC_MAX : (s < ACC_MIN ? ACC_MIN : s);
   endfunction

   function automatic longint clamp_cmd(longint v, longint lim);
      longint l;
      l = lim > CMD_MAX ? CMD_MAX : lim;
      return v > l ? l : (v < -l ? -l : v);
   endfunction

   function automatic guidance_word_type steer(longint pn, longint pe, longint alt, longint hd);
      guidance_word_type w;
      longint dn, de, dh, n, bearing, err, herr, sum;
      dn = route_north[target] - pn;
      de = route_east[target] - pe;
      dh = route_height[target] - alt;
      if (magnitude(dn) <= NEAR_MAX && magnitude(de) <= NEAR_MAX && magnitude(dh) <= NEAR_MAX
          && dn * dn + de * de + dh * dh <= radius * radius) begin
         n = route_len < 1 ? 1 :
             (route_len > wgc_pkg::WAYPOINTS ? wgc_pkg::WAYPOINTS : route_len);
         if (target + 1 < n) target++;
         else finished = 1'b1;
      end
      bearing = -bearing_atan2(route_east[target] - pe, route_north[target] - pn);
      err = hd - bearing;
      while (err > HALF_TURN) err -= FULL_TURN;
      while (err <= -HALF_TURN) err += FULL_TURN;
      roll_acc = saturate_acc(roll_acc + err * roll_i);
      sum = err * roll_p + roll_acc;
      w.roll_cmd = 8'(clamp_cmd(sum / 16384, roll_lim));
      herr = route_height[target] - alt;
      pitch_acc = saturate_acc(pitch_acc + herr * pitch_i);
      sum = herr * pitch_p + pitch_acc;
      w.pitch_cmd = 8'(clamp_cmd(sum / 4096, pitch_lim));
      w.target_index = 5'(target);
      w.final_reached = finished;
      return w;
   endfunction

   assign pending = command_queue.size();

   always @(posedge clock) begin
      guidance_word_type got, want;
      int unsigned slot;
      if (reset) begin
         command_queue.delete();
         fail_count = 0;
         target = 0; roll_acc = 0; pitch_acc = 0; finished = 1'b0;
         radius = 120; roll_p = 282; roll_i = 0; pitch_p = 1250; pitch_i = 0;
         roll_lim = 30; pitch_lim = 20; route_len = 20;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               wgc_pkg::CSR_CAPTURE_RADIUS: radius    = csr_data;
               wgc_pkg::CSR_ROLL_P_GAIN:    roll_p    = csr_data;
               wgc_pkg::CSR_ROLL_I_GAIN:    roll_i    = csr_data;
               wgc_pkg::CSR_PITCH_P_GAIN:   pitch_p   = csr_data;
               wgc_pkg::CSR_PITCH_I_GAIN:   pitch_i   = csr_data;
               wgc_pkg::CSR_ROLL_LIMIT:     roll_lim  = csr_data[6:0];
               wgc_pkg::CSR_PITCH_LIMIT:    pitch_lim = csr_data[6:0];
               wgc_pkg::CSR_WAYPOINT_COUNT: route_len = csr_data[5:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == wgc_pkg::MODE_LOAD[0]) begin
               slot = req_tdata[4:0];
               route_north[slot]  = longint'($signed(req_tdata[24:5]));
               route_east[slot]   = longint'($signed(req_tdata[44:25]));
               route_height[slot] = longint'($signed(req_tdata[64:45]));
            end else begin
               command_queue.push_back(steer(longint'($signed(req_tdata[84:65])),
                                             longint'($signed(req_tdata[104:85])),
                                             longint'($signed(req_tdata[124:105])),
                                             longint'($signed(req_tdata[139:125]))));
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[21:0];
            if (command_queue.size() == 0) begin
               $error("unexpected result word %h", rsp_tdata);
               fail_count++;
            end else begin
               want = command_queue.pop_front();
               if (got.roll_cmd !== want.roll_cmd) begin
                  $error("roll_cmd expected %0d got %0d",
                         $signed(want.roll_cmd), $signed(got.roll_cmd));
                  fail_count++;
               end
               if (got.pitch_cmd !== want.pitch_cmd) begin
                  $error("pitch_cmd expected %0d got %0d",
                         $signed(want.pitch_cmd), $signed(got.pitch_cmd));
                  fail_count++;
               end
               if (got.target_index !== want.target_index) begin
                  $error("target_index expected %0d got %0d",
                         want.target_index, got.target_index);
                  fail_count++;
               end
               if (got.final_reached !== want.final_reached) begin
                  $error("final_reached expected %0d got %0d",
                         want.final_reached, got.final_reached);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule
`default_nettype wire

### tb/tb_waypoint_guidance_controller_core.sv
`default_nettype none
module tb_waypoint_guidance_controller_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic MODE_TELEMETRY = 1'b1;
   localparam int   PHASES         = 6;
   localparam int   PHASE_WORDS    = 250;
   localparam int   IDLE_LIMIT     = 5000;

   logic clock, reset;
   logic req_tvalid, req_tready, req_tuser;
   logic [wgc_pkg::REQ_DATA_BITS-1:0] req_tdata;
   logic rsp_tvalid, rsp_tready;
   logic [wgc_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic csr_valid, csr_ready;
   logic [wgc_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [wgc_pkg::CSR_DATA_BITS-1:0] csr_data;
   int fail_count, pending;

   longint wp_north [wgc_pkg::WAYPOINTS];
   longint wp_east [wgc_pkg::WAYPOINTS];
   longint wp_height [wgc_pkg::WAYPOINTS];
   int unsigned cursor = 0;
   longint near_span;
   int burst_left;
   int idle_cycles = 0;
   int stall_count = 0;
   int unsigned stall_mode = 0;

   // per phase: radius, roll p, roll i, pitch p, pitch i, roll limit, pitch limit, count
   logic [15:0] phase_regs [PHASES][8] = '{
      '{16'd120,   16'd282,   16'd0,     16'd1250,  16'd0,     16'd30,  16'd20,  16'd20},
      '{16'd400,   16'd282,   16'd20,    16'd1250,  16'd5,     16'd30,  16'd20,  16'd6},
      '{16'd0,     16'd0,     16'd0,     16'd0,     16'd0,     16'd0,   16'd0,   16'd0},
      '{16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd90,  16'd90,  16'd1},
      '{16'd2000,  16'd1000,  16'd300,   16'd4000,  16'd100,   16'd127, 16'd100, 16'd32},
      '{16'd800,   16'd500,   16'd65535, 16'd800,   16'd65535, 16'd45,  16'd91,  16'd63}};

   waypoint_guidance_controller_core u_dut (.*);

   waypoint_guidance_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic longint span_rand(longint lo, longint hi);
      return lo + longint'($urandom_range(32'(hi - lo)));
   endfunction

   function automatic logic [wgc_pkg::REQ_DATA_BITS-1:0] pack_word(
      logic [4:0] slot, longint ln, longint le, longint lh,
      longint pn, longint pe, longint alt, longint hd);
      return {4'b0, hd[14:0], alt[19:0], pe[19:0], pn[19:0],
              lh[19:0], le[19:0], ln[19:0], slot};
   endfunction

   function automatic longint coord20(longint v);
      return longint'($signed(v[19:0]));
   endfunction

   task automatic push_word(logic mode, logic [wgc_pkg::REQ_DATA_BITS-1:0] data);
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic load_slot(int slot, longint n, longint e, longint h);
      wp_north[slot] = coord20(n);
      wp_east[slot] = coord20(e);
      wp_height[slot] = coord20(h);
      push_word(wgc_pkg::MODE_LOAD[0], pack_word(5'(slot), n, e, h,
                span_rand(-524288, 524287), span_rand(-524288, 524287),
                span_rand(-524288, 524287), $urandom));
   endtask

   task automatic telemetry(longint pn, longint pe, longint alt, longint hd);
      push_word(MODE_TELEMETRY, pack_word(5'($urandom), span_rand(-524288, 524287),
                span_rand(-524288, 524287), span_rand(-524288, 524287), pn, pe, alt, hd));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic random_word();
      longint hd;
      int unsigned c;
      if ($urandom_range(99) < 30) hd = span_rand(-16384, 16383);
      else hd = span_rand(-11520, 11520);
      c = cursor;
      if ($urandom_range(99) < 12) begin
         if ($urandom_range(3) == 0)
            load_slot($urandom_range(31), span_rand(-524288, 524287),
                      span_rand(-524288, 524287), span_rand(-524288, 524287));
         else
            load_slot($urandom_range(31), span_rand(-3000, 3000), span_rand(-3000, 3000),
                      span_rand(-3000, 3000));
      end else if ($urandom_range(99) < 65) begin
         telemetry(coord20(wp_north[c] + span_rand(-near_span, near_span)),
                   coord20(wp_east[c] + span_rand(-near_span, near_span)),
                   coord20(wp_height[c] + span_rand(-near_span, near_span)), hd);
      end else if ($urandom_range(1) == 0) begin
         telemetry(span_rand(-524288, 524287), span_rand(-524288, 524287),
                   span_rand(-524288, 524287), hd);
      end else begin
         telemetry(span_rand(-5000, 5000), span_rand(-5000, 5000),
                   span_rand(-5000, 5000), hd);
      end
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(4) == 0) ? 80 : $urandom_range(1, 20);
         if ($urandom_range(3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   endtask

   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) cursor <= rsp_tdata[20:16];
      stall_count <= stall_count + 1;
      if (stall_count % 300 == 0) stall_mode <= $urandom_range(3);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= $urandom_range(1);
         2: rsp_tready <= (stall_count % 8 == 0);
         default: rsp_tready <= (stall_count % 40) < 25;
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      burst_left = 10;
      near_span = 60;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int s = 0; s < wgc_pkg::WAYPOINTS - 1; s++)
         load_slot(s, span_rand(-2000, 2000), span_rand(-2000, 2000), span_rand(-2000, 2000));
      load_slot(wgc_pkg::WAYPOINTS - 1, 524287, -524288, 524287);
      telemetry(wp_north[0], wp_east[0], wp_height[0], 0);
      telemetry(wp_north[1], wp_east[1], wp_height[1] + 200, 11520);
      telemetry(wp_north[1] - 300, wp_east[1] + 300, wp_height[1], -11520);
      telemetry(524287, 524287, 524287, 16383);
      telemetry(-524288, -524288, -524288, -16384);
      telemetry(wp_north[1] + 100000, wp_east[1], wp_height[1], 5000);
      telemetry(wp_north[1] + 40, wp_east[1] - 40, wp_height[1], -7000);
      telemetry(wp_north[cursor] - 5, wp_east[cursor], wp_height[cursor], 0);

      for (int p = 0; p < PHASES; p++) begin
         drain();
         repeat (60) @(posedge clock);
         for (int r = 0; r < 8; r++) write_reg(3'(r), phase_regs[p][r]);
         csr_valid <= 1'b0;
         near_span = (phase_regs[p][0] == 0) ? 2 : (phase_regs[p][0] * 2) / 3;
         @(posedge clock);
         for (int i = 0; i < PHASE_WORDS; i++) begin
            if (p == 1 && i == PHASE_WORDS / 2) drain();
            random_word();
         end
      end

      drain();
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
`default_nettype wire
